[hdl/nfha_pkg.sv]
// Shared types, constants and helpers of the next-fit heap allocator.
package nfha_pkg;

	localparam int HEAP_BYTES_MAX = 65536;
	localparam int HEADER_BYTES   = 24;
	localparam int TASK_ID_BITS   = 8;
	localparam int HEAP_WORDS     = HEAP_BYTES_MAX / 4;
	localparam int IDX_W          = $clog2(HEAP_WORDS);
	localparam int LEN_W          = $clog2(HEAP_BYTES_MAX) + 1;
	localparam int SIZE_W         = LEN_W - 1;
	localparam int NEED_W         = 25;
	localparam int CNT_W          = 12;
	localparam int SPLIT_MIN      = HEADER_BYTES + 4;

	localparam logic [1:0] KIND_INIT  = 2'd0;
	localparam logic [1:0] KIND_ALLOC = 2'd1;
	localparam logic [1:0] KIND_FREE  = 2'd2;
	localparam logic [1:0] KIND_COUNT = 2'd3;

	localparam logic [1:0] CFG_HEAP_BASE    = 2'd0;
	localparam logic [1:0] CFG_HEAP_BYTES   = 2'd1;
	localparam logic [1:0] CFG_KERNEL_READY = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic                    start;
		logic                    alloc;
		logic [TASK_ID_BITS-1:0] owner;
		logic [SIZE_W-1:0]       size;
		idx_t                    prev;
		logic                    prev_ok;
	} hdr_t;

	typedef struct packed {
		logic we;
		idx_t waddr;
		hdr_t wdata;
		idx_t raddr;
	} mreq_t;

	typedef struct packed {
		logic [31:0] base;
		logic [16:0] bytes;
		logic        kready;
	} cfg_t;

	typedef struct packed {
		logic ok;
		idx_t idx;
	} nxt_t;

	function automatic nxt_t next_of(idx_t idx, logic [SIZE_W-1:0] size,
			logic [LEN_W-1:0] len);
		logic [LEN_W:0] sum;
		nxt_t r;
		sum = (LEN_W+1)'({idx, 2'b00}) + (LEN_W+1)'(HEADER_BYTES) + (LEN_W+1)'(size);
		r.ok = sum < {1'b0, len};
		r.idx = sum[IDX_W+1:2];
		return r;
	endfunction

endpackage

[hdl/nfha_hdr_ram.sv]
// Header store: one write port, one registered read port with write forwarding.
module nfha_hdr_ram (
	input  logic           clk,
	input  nfha_pkg::mreq_t req,
	output nfha_pkg::hdr_t  rdata
);
	import nfha_pkg::*;

	hdr_t mem [HEAP_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.we && req.waddr == req.raddr) begin
			rdata <= req.wdata;
		end else begin
			rdata <= mem[req.raddr];
		end
	end
endmodule

[hdl/nfha_seq.sv]
// Request sequencer: walks and rewrites block headers in the header store.
module nfha_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nfha_pkg::cfg_t         cfg,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic [23:0]           request_size,
	input  logic [31:0]           block_address,
	input  logic [7:0]            task_id,
	output nfha_pkg::mreq_t        mreq,
	input  nfha_pkg::hdr_t         rdata,
	output logic                  done,
	output logic                  status,
	output logic [31:0]           user_address,
	output logic [11:0]           small_count
);
	import nfha_pkg::*;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE,
		S_A_LRD, S_A_LWT, S_A_RD, S_A_WT, S_A_ARD, S_A_AWT, S_A_WCUR,
		S_F_RD, S_F_WT, S_F_PRD, S_F_PWT,
		S_M_LRD, S_M_LWT, S_M_NEXT, S_M_RD, S_M_WT, S_M_ARD, S_M_AWT, S_M_WC,
		S_C_RD, S_C_WT
	} state_t;

	state_t                  state_q;
	idx_t                    rd_idx_q, waddr_q, cur_q, start_q, nx_q, nb_q, last_q, clr_q;
	logic                    we_q, ready_q, last_valid_q, done_q, status_q;
	hdr_t                    wdata_q, cur_e_q;
	logic [NEED_W-1:0]       need_q;
	logic [TASK_ID_BITS-1:0] task_q;
	logic [CNT_W-1:0]        n_q, cnt_q;
	logic [31:0]             base_q, addr_q;
	logic [LEN_W-1:0]        len_q;

	nxt_t              nx_rd, nx_cur, nx_m;
	logic [SIZE_W-1:0] msize;
	logic [NEED_W-1:0] need_in;
	logic [31:0]       blk, off;
	logic              free_ok, fits, split;
	logic [16:0]       ilen;
	logic [CNT_W-1:0]  n_new;

	always_comb begin
		nx_rd   = next_of(cur_q, rdata.size, len_q);
		nx_cur  = next_of(cur_q, cur_e_q.size, len_q);
		msize   = cur_e_q.size + SIZE_W'(HEADER_BYTES) + rdata.size;
		nx_m    = next_of(cur_q, msize, len_q);
		need_in = (NEED_W'(request_size) + NEED_W'(3)) & ~NEED_W'(3);
		blk     = block_address - 32'(HEADER_BYTES);
		off     = blk - base_q;
		free_ok = (blk >= base_q) && (off < 32'(len_q)) && (off[1:0] == 2'b00);
		ilen    = (cfg.bytes > 17'(HEAP_BYTES_MAX)) ? 17'(HEAP_BYTES_MAX) : cfg.bytes;
		ilen    = ilen & ~17'd3;
		fits    = !rdata.alloc && (NEED_W'(rdata.size) >= need_q);
		split   = (26'(rdata.size) >= 26'(need_q) + 26'(SPLIT_MIN));
		n_new   = n_q + CNT_W'(!rdata.alloc && (NEED_W'(rdata.size) < need_q));
	end

	assign busy         = (state_q != S_IDLE);
	assign mreq.we      = we_q;
	assign mreq.waddr   = waddr_q;
	assign mreq.wdata   = wdata_q;
	assign mreq.raddr   = rd_idx_q;
	assign done         = done_q;
	assign status       = status_q;
	assign user_address = addr_q;
	assign small_count  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			we_q         <= 1'b0;
			clr_q        <= '0;
			ready_q      <= 1'b0;
			last_valid_q <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= 1'b0;
			addr_q       <= '0;
			cnt_q        <= '0;
			len_q        <= '0;
			base_q       <= '0;
		end else begin
			we_q   <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					we_q    <= 1'b1;
					waddr_q <= clr_q;
					wdata_q <= '0;
					clr_q   <= clr_q + IDX_W'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						need_q <= need_in;
						task_q <= task_id[TASK_ID_BITS-1:0];
						addr_q <= '0;
						cnt_q  <= '0;
						case (kind)
							KIND_INIT: begin
								done_q  <= 1'b1;
								status_q <= 1'b1;
								if (!ready_q && cfg.kready && ilen >= 17'(SPLIT_MIN)) begin
									status_q <= 1'b0;
									base_q   <= cfg.base;
									len_q    <= ilen;
									ready_q  <= 1'b1;
									we_q     <= 1'b1;
									waddr_q  <= '0;
									wdata_q  <= '{start: 1'b1, alloc: 1'b0, owner: '0,
										size: SIZE_W'(ilen - 17'(HEADER_BYTES)),
										prev: '0, prev_ok: 1'b0};
								end
							end
							KIND_ALLOC: begin
								if (!ready_q || request_size == '0) begin
									done_q   <= 1'b1;
									status_q <= 1'b1;
								end else if (last_valid_q) begin
									cur_q    <= last_q;
									rd_idx_q <= last_q;
									state_q  <= S_A_LRD;
								end else begin
									cur_q    <= '0;
									start_q  <= '0;
									rd_idx_q <= '0;
									state_q  <= S_A_RD;
								end
							end
							KIND_FREE: begin
								if (!ready_q || (block_address != '0 && !free_ok)) begin
									done_q   <= 1'b1;
									status_q <= 1'b1;
								end else if (block_address == '0) begin
									done_q   <= 1'b1;
									status_q <= 1'b0;
								end else begin
									cur_q    <= off[IDX_W+1:2];
									rd_idx_q <= off[IDX_W+1:2];
									state_q  <= S_F_RD;
								end
							end
							default: begin
								if (!ready_q) begin
									done_q   <= 1'b1;
									status_q <= 1'b0;
								end else begin
									n_q      <= '0;
									cur_q    <= '0;
									rd_idx_q <= '0;
									state_q  <= S_C_RD;
								end
							end
						endcase
					end
				end
				S_A_LRD: state_q <= S_A_LWT;
				S_A_LWT: begin
					start_q  <= nx_rd.ok ? nx_rd.idx : '0;
					cur_q    <= nx_rd.ok ? nx_rd.idx : '0;
					rd_idx_q <= nx_rd.ok ? nx_rd.idx : '0;
					state_q  <= S_A_RD;
				end
				S_A_RD: state_q <= S_A_WT;
				S_A_WT: begin
					if (fits) begin
						cur_e_q       <= rdata;
						cur_e_q.alloc <= 1'b1;
						cur_e_q.owner <= task_q;
						state_q       <= S_A_WCUR;
						if (split) begin
							cur_e_q.size <= SIZE_W'(need_q);
							nb_q    <= cur_q + IDX_W'(HEADER_BYTES / 4) + need_q[IDX_W+1:2];
							we_q    <= 1'b1;
							waddr_q <= cur_q + IDX_W'(HEADER_BYTES / 4) + need_q[IDX_W+1:2];
							wdata_q <= '{start: 1'b1, alloc: 1'b0, owner: '0,
								size: SIZE_W'(26'(rdata.size) - 26'(need_q) - 26'(HEADER_BYTES)),
								prev: cur_q, prev_ok: 1'b1};
							if (nx_rd.ok) begin
								nx_q     <= nx_rd.idx;
								rd_idx_q <= nx_rd.idx;
								state_q  <= S_A_ARD;
							end
						end
					end else if ((nx_rd.ok ? nx_rd.idx : '0) == start_q) begin
						done_q   <= 1'b1;
						status_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						cur_q    <= nx_rd.ok ? nx_rd.idx : '0;
						rd_idx_q <= nx_rd.ok ? nx_rd.idx : '0;
						state_q  <= S_A_RD;
					end
				end
				S_A_ARD: state_q <= S_A_AWT;
				S_A_AWT: begin
					we_q            <= 1'b1;
					waddr_q         <= nx_q;
					wdata_q         <= rdata;
					wdata_q.prev    <= nb_q;
					wdata_q.prev_ok <= 1'b1;
					state_q         <= S_A_WCUR;
				end
				S_A_WCUR: begin
					we_q         <= 1'b1;
					waddr_q      <= cur_q;
					wdata_q      <= cur_e_q;
					last_valid_q <= 1'b1;
					last_q       <= cur_q;
					done_q       <= 1'b1;
					status_q     <= 1'b0;
					addr_q       <= base_q + 32'({cur_q, 2'b00}) + 32'(HEADER_BYTES);
					state_q      <= S_IDLE;
				end
				S_F_RD: state_q <= S_F_WT;
				S_F_WT: begin
					if (!rdata.start || !rdata.alloc ||
							(rdata.owner != task_q && task_q != '0)) begin
						done_q   <= 1'b1;
						status_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						cur_e_q       <= rdata;
						cur_e_q.alloc <= 1'b0;
						cur_e_q.owner <= '0;
						we_q          <= 1'b1;
						waddr_q       <= cur_q;
						wdata_q       <= rdata;
						wdata_q.alloc <= 1'b0;
						wdata_q.owner <= '0;
						last_valid_q  <= 1'b0;
						if (rdata.prev_ok) begin
							rd_idx_q <= rdata.prev;
							state_q  <= S_F_PRD;
						end else begin
							state_q <= S_M_NEXT;
						end
					end
				end
				S_F_PRD: state_q <= S_F_PWT;
				S_F_PWT: begin
					if (!rdata.alloc) begin
						cur_q    <= '0;
						rd_idx_q <= '0;
						state_q  <= S_M_LRD;
					end else begin
						state_q <= S_M_NEXT;
					end
				end
				S_M_LRD: state_q <= S_M_LWT;
				S_M_LWT: begin
					cur_e_q <= rdata;
					state_q <= S_M_NEXT;
				end
				S_M_NEXT: begin
					if (!nx_cur.ok) begin
						done_q   <= 1'b1;
						status_q <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						nx_q     <= nx_cur.idx;
						rd_idx_q <= nx_cur.idx;
						state_q  <= S_M_RD;
					end
				end
				S_M_RD: state_q <= S_M_WT;
				S_M_WT: begin
					if (!cur_e_q.alloc && !rdata.alloc) begin
						cur_e_q.size  <= msize;
						we_q          <= 1'b1;
						waddr_q       <= nx_q;
						wdata_q       <= rdata;
						wdata_q.start <= 1'b0;
						if (nx_m.ok) begin
							nb_q     <= nx_m.idx;
							rd_idx_q <= nx_m.idx;
							state_q  <= S_M_ARD;
						end else begin
							state_q <= S_M_WC;
						end
					end else begin
						cur_q   <= nx_q;
						cur_e_q <= rdata;
						state_q <= S_M_NEXT;
					end
				end
				S_M_ARD: state_q <= S_M_AWT;
				S_M_AWT: begin
					we_q            <= 1'b1;
					waddr_q         <= nb_q;
					wdata_q         <= rdata;
					wdata_q.prev    <= cur_q;
					wdata_q.prev_ok <= 1'b1;
					state_q         <= S_M_WC;
				end
				S_M_WC: begin
					we_q    <= 1'b1;
					waddr_q <= cur_q;
					wdata_q <= cur_e_q;
					state_q <= S_M_NEXT;
				end
				S_C_RD: state_q <= S_C_WT;
				S_C_WT: begin
					n_q <= n_new;
					if (!nx_rd.ok) begin
						done_q   <= 1'b1;
						status_q <= 1'b0;
						cnt_q    <= n_new;
						state_q  <= S_IDLE;
					end else begin
						cur_q    <= nx_rd.idx;
						rd_idx_q <= nx_rd.idx;
						state_q  <= S_C_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[hdl/next_fit_heap_allocator_top.sv]
// Top level of the next-fit heap allocator: configuration registers, sequencer, header store.
//
// channel   signals                                          handshake
// request   kind request_size block_address task_id          start & !busy
// result    status user_address small_count                  done, one cycle
// config    cfg_index cfg_data                               cfg_valid & cfg_ready
//
// Init, free of null and requests refused up front are answered from idle. Allocate and
// count read each block header they visit; free walks the headers to the heap end and
// merges adjacent free blocks, all through the single read port of the header store.
// After reset a clearing pass over all 16384 header words holds busy high.
// Configuration writes are taken at any time; the result cannot be stalled.
module next_fit_heap_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [23:0] request_size,
	input  logic [31:0] block_address,
	input  logic [7:0]  task_id,
	output logic        done,
	output logic        status,
	output logic [31:0] user_address,
	output logic [11:0] small_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import nfha_pkg::*;

	cfg_t  cfg_q;
	mreq_t mreq;
	hdr_t  rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base   <= '0;
			cfg_q.bytes  <= 17'(HEAP_BYTES_MAX);
			cfg_q.kready <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEAP_BASE:    cfg_q.base   <= cfg_data;
				CFG_HEAP_BYTES:   cfg_q.bytes  <= cfg_data[16:0];
				CFG_KERNEL_READY: cfg_q.kready <= cfg_data[0];
				default: ;
			endcase
		end
	end

	nfha_seq u_seq (
		.clk, .arst_n, .cfg(cfg_q), .start, .busy, .kind, .request_size,
		.block_address, .task_id, .mreq, .rdata, .done, .status,
		.user_address, .small_count
	);

	nfha_hdr_ram u_ram (.clk, .req(mreq), .rdata);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !done |=> busy || done)
		else $error("item accepted without work or result");
	a_addr_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> user_address == '0 && small_count == '0)
		else $error("failed item carries payload");
	a_idle_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still busy");
endmodule
